[design/grm_pkg.sv]
package grm_pkg;

  // Field widths of the stream payloads.
  localparam int ColumnW   = 12;
  localparam int CellW     = 3;
  localparam int CodeW     = 3;
  localparam int StepOutW  = 8;
  localparam int RowOutW   = 12;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 40;

  // Configuration port and register indexes.
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 20;
  localparam logic [CfgIdxW-1:0] CfgPosX   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPosY   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStart  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSpan   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRows   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCols   = 3'd5;

  // Request kinds carried in tuser.
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdCast  = 1'b1;

  // Datapath widths.
  localparam int PosW      = 25;
  localparam int IdxW      = 11;
  localparam int StepW     = 14;
  localparam int AngW      = 16;
  localparam int ScrW      = 13;
  localparam int DivNW     = 28;
  localparam int DivDW     = 13;
  localparam int DivCntW   = 5;
  localparam logic [ScrW-1:0] RowsMax = 13'd4096;

  // Sine table constants, Q.30.
  localparam longint unsigned PiQ30    = 64'd3373259426;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned TwoPiQ30 = 64'd6746518852;
  localparam longint TenthDiv          = 64'sd163840;

  // Reciprocal of five for the pad division, 18 fraction bits.
  localparam logic [15:0] RecipFive = 16'd52429;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ANG_GO,
    ST_ANG_WAIT,
    ST_TAB,
    ST_LOAD,
    ST_MARCH,
    ST_HGT_GO,
    ST_HGT_WAIT,
    ST_PAD,
    ST_FIN
  } grm_state_e;

  typedef struct packed {
    logic clr_wr;
    logic map_wr;
    logic cast_load;
    logic ang_start;
    logic hgt_start;
    logic tab_load;
    logic pos_load;
    logic march_step;
    logic stop;
    logic stop_fail;
    logic pad_load;
    logic out_load;
  } grm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic oob;
    logic hit;
    logic at_limit;
    logic cnt_zero;
    logic out_free;
  } grm_stat_t;

endpackage

[design/grid_ray_march_column.sv]
// Grid ray marcher for one screen column.
// Requests arrive on the s_axis channel; tuser selects the kind. A write
// request stores one wall code into the map and gives no result. A cast
// request marches a ray for one column and returns one result on m_axis.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// while no request is in flight; the user is bound to this, the block does
// not enforce it. A cast uses two passes of the shared restoring divider
// (view angle, then wall height); between them come the table lookup, the
// position load, the march steps and the stopping test, and after the
// second come the pad arithmetic and the result load.
// A cast that stops at the start cell skips the height division and the pad
// arithmetic. The next request can be taken in the cycle after the result
// is loaded. Write requests are stored in the cycle they are accepted. One
// request is worked on at a time. After reset the map is cleared, one cell
// per cycle, before the first request is taken.
// The result waits in an output register; the next request is taken while
// it waits, and a stalled receiver only holds the following cast at its end.
module grid_ray_march_column
  import grm_pkg::*;
#(
  parameter int MAP_DIM      = 8,
  parameter int MAX_STEPS    = 128,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // column[11:0], cell_row[14:12], cell_col[17:15], cell_value[20:18]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // wall_code[2:0], step_count[10:3], span_start[22:11], span_end[34:23],
  // ray_status[35]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  grm_cmd_t  cmd;
  grm_stat_t stat;

  grm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  grm_datapath #(
    .MAP_DIM      (MAP_DIM),
    .MAX_STEPS    (MAX_STEPS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[design/grm_div.sv]
module grm_div
  import grm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] dividend_i,
  input  logic [DivDW-1:0] divisor_i,
  output logic [DivNW-1:0] quotient_o,
  output logic             done_o
);

  logic [DivNW-1:0]   quo_q, quo_d;
  logic [DivDW-1:0]   rem_q, rem_d;
  logic [DivDW-1:0]   dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDW:0]     rem_sh, trial;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    rem_sh = {rem_q, quo_q[DivNW-1]};
    trial  = rem_sh - {1'b0, dvs_q};
    quo_d  = {quo_q[DivNW-2:0], ~trial[DivDW]};
    rem_d  = trial[DivDW] ? rem_sh[DivDW-1:0] : trial[DivDW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(DivNW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivNW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[design/grm_datapath.sv]
module grm_datapath
  import grm_pkg::*;
#(
  parameter int MAP_DIM      = 8,
  parameter int MAX_STEPS    = 128,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  grm_cmd_t            cmd_i,
  output grm_stat_t           stat_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int Depth = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(MAX_STEPS + 1);
  localparam int SW    = $clog2(SINE_ENTRIES);

  // Step component of table entry k: Q.30 sine times one tenth, as Q.16.
  function automatic logic signed [StepW-1:0] step_entry(int k);
    longint unsigned x, x2, term;
    longint sum, mag, q;
    logic neg;
    x   = (TwoPiQ30 * longint'(k)) / SINE_ENTRIES;
    neg = 1'b0;
    if (x >= PiQ30) begin
      neg = 1'b1;
      x   = x - PiQ30;
    end
    if (x > HalfPiQ30) x = PiQ30 - x;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    mag  = sum < 0 ? -sum : sum;
    q    = (mag + TenthDiv / 2) / TenthDiv;
    if (neg != (sum < 0)) q = -q;
    return StepW'(q);
  endfunction

  // Cell index of a position: truncated toward zero, plus one.
  function automatic logic signed [IdxW-1:0] cell_idx(logic signed [PosW-1:0] p);
    logic [PosW-1:0] m;
    logic signed [IdxW-1:0] t;
    m = p[PosW-1] ? PosW'(-p) : PosW'(p);
    t = $signed(IdxW'(m[PosW-1:16]));
    return p[PosW-1] ? IdxW'(1) - t : t + IdxW'(1);
  endfunction

  // Step table, built at elaboration.
  logic signed [StepW-1:0] step_tab [SINE_ENTRIES];
  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_tab
    assign step_tab[g] = step_entry(g);
  end

  // Configuration registers.
  logic signed [CfgDataW-1:0] pos_x_q, pos_y_q;
  logic [AngW-1:0]            start_q, span_q;
  logic [ScrW-1:0]            rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= 20'sd196608;
      pos_y_q <= 20'sd196608;
      start_q <= '0;
      span_q  <= 16'd10923;
      rows_q  <= 13'd480;
      cols_q  <= 13'd640;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPosX:  pos_x_q <= $signed(cfg_data_i);
        CfgPosY:  pos_y_q <= $signed(cfg_data_i);
        CfgStart: start_q <= cfg_data_i[AngW-1:0];
        CfgSpan:  span_q  <= cfg_data_i[AngW-1:0];
        CfgRows:  rows_q  <= cfg_data_i[ScrW-1:0];
        CfgCols:  cols_q  <= cfg_data_i[ScrW-1:0];
        default: ;
      endcase
    end
  end

  // Effective screen size: zero counts as one, rows capped.
  logic [ScrW-1:0] rows_e, cols_e;
  assign cols_e = (cols_q == '0) ? ScrW'(1) : cols_q;
  always_comb begin
    rows_e = rows_q;
    if (rows_q == '0) rows_e = ScrW'(1);
    if (rows_q > RowsMax) rows_e = RowsMax;
  end

  // Latched column of the cast request.
  logic [ColumnW-1:0] column_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cast_load) column_q <= in_data_i[ColumnW-1:0];
  end

  // Shared divider: view angle first, wall height later.
  logic [DivNW-1:0] div_a, div_q;
  logic [DivDW-1:0] div_b;
  logic [CW-1:0]    cnt_q;
  logic             div_done;

  always_comb begin
    if (cmd_i.hgt_start) begin
      div_a = DivNW'(rows_e) * DivNW'(10);
      div_b = DivDW'(cnt_q);
    end else begin
      div_a = DivNW'(span_q) * DivNW'(column_q);
      div_b = cols_e;
    end
  end

  grm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.ang_start | cmd_i.hgt_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quotient_o (div_q),
    .done_o     (div_done)
  );

  // Step vector from the table.
  logic [AngW-1:0] ang, ang_c;
  logic [SW-1:0]   sin_idx, cos_idx;
  logic signed [StepW-1:0] dx_q, dy_q;

  assign ang     = start_q + div_q[AngW-1:0];
  assign ang_c   = ang + AngW'(16384);
  assign sin_idx = SW'((32'(ang) * 32'(SINE_ENTRIES)) >> 16);
  assign cos_idx = SW'((32'(ang_c) * 32'(SINE_ENTRIES)) >> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_load) begin
      dx_q <= step_tab[cos_idx];
      dy_q <= step_tab[sin_idx];
    end
  end

  // March position and the cell it lies in.
  logic signed [PosW-1:0] mx_q, my_q, mx_d, my_d;
  logic signed [IdxW-1:0] ri, ci;
  logic                   in_map;
  logic [AW-1:0]          rd_addr;

  always_comb begin
    if (cmd_i.pos_load) begin
      mx_d = PosW'(pos_x_q);
      my_d = PosW'(pos_y_q);
    end else begin
      mx_d = mx_q + PosW'(dx_q);
      my_d = my_q + PosW'(dy_q);
    end
    ri      = cell_idx(my_d);
    ci      = cell_idx(mx_d);
    in_map  = (ri >= 0) && (ri < IdxW'(MAP_DIM)) && (ci >= 0) && (ci < IdxW'(MAP_DIM));
    rd_addr = AW'(ri * IdxW'(MAP_DIM) + ci);
  end

  logic oob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.pos_load) begin
      cnt_q <= '0;
    end else if (cmd_i.march_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_load || cmd_i.march_step) begin
      mx_q  <= mx_d;
      my_q  <= my_d;
      oob_q <= ~in_map;
    end
  end

  // Map memory with clearing pass after reset.
  logic [CodeW-1:0] map_mem [Depth];
  logic [CodeW-1:0] rd_q;
  logic [AW-1:0]    clr_q, wr_addr;
  logic [CellW-1:0] w_row, w_col, w_val;
  logic             w_ok;

  assign w_col   = in_data_i[ColumnW+CellW +: CellW];
  assign w_row   = in_data_i[ColumnW +: CellW];
  assign w_val   = in_data_i[ColumnW+2*CellW +: CellW];
  assign w_ok    = (32'(w_row) < MAP_DIM) && (32'(w_col) < MAP_DIM);
  assign wr_addr = AW'(32'(w_row) * MAP_DIM + 32'(w_col));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      map_mem[clr_q] <= '0;
    end else if (cmd_i.map_wr && w_ok) begin
      map_mem[wr_addr] <= w_val;
    end
    rd_q <= map_mem[rd_addr];
  end

  // March outcome.
  logic [CodeW-1:0] code_q;
  logic             fail_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.stop) begin
      code_q <= cmd_i.stop_fail ? '0 : rd_q;
      fail_q <= cmd_i.stop_fail;
    end
  end

  // Pad = (rows - size) / 5 toward zero, via reciprocal multiply.
  logic signed [17:0] diff;
  logic [16:0]        dmag;
  logic [32:0]        prod;
  logic signed [16:0] pad_q;
  logic [16:0]        pmag;

  assign diff = $signed({5'b0, rows_e}) - $signed({2'b0, div_q[15:0]});
  assign dmag = diff[17] ? 17'(-diff) : 17'(diff);
  assign prod = 33'(dmag) * 33'(RecipFive);
  assign pmag = 17'(prod[32:18]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pad_load) pad_q <= diff[17] ? -$signed(pmag) : $signed(pmag);
  end

  // Clamped span and the result register.
  logic signed [17:0] rmax, s0, s1;
  logic [RowOutW-1:0] sp0, sp1;
  logic [StepOutW-1:0] steps_sat;

  always_comb begin
    rmax = $signed({5'b0, rows_e}) - 18'sd1;
    if (cnt_q == '0) begin
      s0 = '0;
      s1 = rmax;
    end else begin
      s0 = 18'(pad_q);
      s1 = $signed({5'b0, rows_e}) - 18'(pad_q);
      if (s0 < 0) s0 = '0;
      if (s1 > rmax) s1 = rmax;
      if (s0 > rmax) s0 = rmax;
      if (s1 < 0) s1 = '0;
    end
    sp0       = s0[RowOutW-1:0];
    sp1       = s1[RowOutW-1:0];
    steps_sat = (32'(cnt_q) > 255) ? '1 : StepOutW'(cnt_q);
  end

  logic                vld_q;
  logic [OutDataW-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= {4'b0, fail_q, sp1, sp0, steps_sat, code_q};
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

  assign stat_o.clr_last = (clr_q == AW'(Depth - 1));
  assign stat_o.div_done = div_done;
  assign stat_o.oob      = oob_q;
  assign stat_o.hit      = (rd_q != '0);
  assign stat_o.at_limit = (32'(cnt_q) >= MAX_STEPS);
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.out_free = ~vld_q | out_ready_i;

endmodule

[design/grm_ctrl.sv]
module grm_ctrl
  import grm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_kind_i,
  output logic      in_ready_o,
  input  grm_stat_t stat_i,
  output grm_cmd_t  cmd_o
);

  grm_state_e state_q, state_d;
  logic       acc;

  assign acc = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:     if (acc && in_kind_i == CmdCast) state_d = ST_ANG_GO;
      ST_ANG_GO:   state_d = ST_ANG_WAIT;
      ST_ANG_WAIT: if (stat_i.div_done) state_d = ST_TAB;
      ST_TAB:      state_d = ST_LOAD;
      ST_LOAD:     state_d = ST_MARCH;
      ST_MARCH: begin
        if (stat_i.oob || stat_i.hit || stat_i.at_limit) begin
          state_d = stat_i.cnt_zero ? ST_FIN : ST_HGT_GO;
        end
      end
      ST_HGT_GO:   state_d = ST_HGT_WAIT;
      ST_HGT_WAIT: if (stat_i.div_done) state_d = ST_PAD;
      ST_PAD:      state_d = ST_FIN;
      ST_FIN:      if (stat_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        cmd_o.map_wr    = acc && (in_kind_i == CmdWrite);
        cmd_o.cast_load = acc && (in_kind_i == CmdCast);
      end
      ST_ANG_GO: cmd_o.ang_start = 1'b1;
      ST_TAB:    cmd_o.tab_load  = 1'b1;
      ST_LOAD:   cmd_o.pos_load  = 1'b1;
      ST_MARCH: begin
        if (stat_i.oob) begin
          cmd_o.stop      = 1'b1;
          cmd_o.stop_fail = 1'b1;
        end else if (stat_i.hit) begin
          cmd_o.stop = 1'b1;
        end else if (stat_i.at_limit) begin
          cmd_o.stop      = 1'b1;
          cmd_o.stop_fail = 1'b1;
        end else begin
          cmd_o.march_step = 1'b1;
        end
      end
      ST_HGT_GO: cmd_o.hgt_start = 1'b1;
      ST_PAD:    cmd_o.pad_load  = 1'b1;
      ST_FIN:    cmd_o.out_load  = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

[tb/grm_march_checker.sv]
module grm_march_checker
  import grm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [0:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MapDim   = 8;
  localparam int MaxSteps = 128;
  localparam int SineN    = 256;

  typedef struct packed {
    logic            status;
    logic [11:0]     span_end;
    logic [11:0]     span_start;
    logic [7:0]      steps;
    logic [CodeW-1:0] code;
  } column_t;

  column_t      column_q[$];
  logic [2:0]   grid[MapDim*MapDim];
  longint       sine_q30[SineN];
  logic signed [19:0] pos_x, pos_y;
  logic [15:0]  start_ang, span_ang;
  logic [12:0]  rows_reg, cols_reg;

  assign pending_o = column_q.size();

  // Q.30 sine of one table entry, Taylor series after quarter-wave folding.
  function automatic longint sine_of(int k);
    longint unsigned x, x2, term;
    longint acc;
    bit neg;
    x = TwoPiQ30 * longint'(k) / SineN;
    neg = 0;
    if (x >= PiQ30) begin
      neg = 1;
      x -= PiQ30;
    end
    if (x > HalfPiQ30) x = PiQ30 - x;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= term;
      else acc += term;
    end
    return neg ? -acc : acc;
  endfunction

  // One component of the tenth-cell step, rounded half away from zero.
  function automatic longint step_of(logic [15:0] ang);
    longint s, q;
    s = sine_q30[(int'(ang) * SineN) >> 16];
    q = ((s < 0 ? -s : s) + TenthDiv / 2) / TenthDiv;
    return s < 0 ? -q : q;
  endfunction

  function automatic longint cell_of(longint p);
    return (p >= 0 ? (p >>> 16) : -((-p) >>> 16)) + 1;
  endfunction

  // Marches one column and returns the expected result.
  function automatic column_t cast_column(logic [11:0] col);
    longint cols, rows, dx, dy, mx, my, r, c, size, pad, s0, s1;
    logic [15:0] ang;
    int steps;
    column_t res;
    cols = (cols_reg == 0) ? 1 : cols_reg;
    rows = (rows_reg == 0) ? 1 : rows_reg;
    if (rows > 4096) rows = 4096;
    ang = 16'(longint'(start_ang) + (longint'(span_ang) * col) / cols);
    dx = step_of(ang + 16'd16384);
    dy = step_of(ang);
    mx = pos_x;
    my = pos_y;
    steps = 0;
    res = '0;
    forever begin
      r = cell_of(my);
      c = cell_of(mx);
      if (r < 0 || r >= MapDim || c < 0 || c >= MapDim) begin
        res.status = 1;
        break;
      end
      res.code = grid[r * MapDim + c];
      if (res.code != 0) break;
      if (steps >= MaxSteps) begin
        res.status = 1;
        break;
      end
      mx += dx;
      my += dy;
      steps++;
    end
    if (res.status) res.code = 0;
    if (steps == 0) begin
      s0 = 0;
      s1 = rows - 1;
    end else begin
      size = (rows * 10) / steps;
      pad = (rows - size) / 5;
      s0 = pad;
      s1 = rows - pad;
      if (s0 < 0) s0 = 0;
      if (s1 > rows - 1) s1 = rows - 1;
      if (s0 > rows - 1) s0 = rows - 1;
      if (s1 < 0) s1 = 0;
    end
    res.steps = (steps > 255) ? 8'd255 : 8'(steps);
    res.span_start = 12'(s0);
    res.span_end = 12'(s1);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s mismatch: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    for (int k = 0; k < SineN; k++) sine_q30[k] = sine_of(k);
  end

  // Track configuration, predict each accepted request, compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    column_t got, want;
    if (!rst_ni) begin
      pos_x = 20'sd196608;
      pos_y = 20'sd196608;
      start_ang = 0;
      span_ang = 16'd10923;
      rows_reg = 13'd480;
      cols_reg = 13'd640;
      foreach (grid[i]) grid[i] = 0;
      column_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPosX:  pos_x = cfg_data_i;
          CfgPosY:  pos_y = cfg_data_i;
          CfgStart: start_ang = cfg_data_i[15:0];
          CfgSpan:  span_ang = cfg_data_i[15:0];
          CfgRows:  rows_reg = cfg_data_i[12:0];
          CfgCols:  cols_reg = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[35:0];
        if (column_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = column_q.pop_front();
          if (got.code != want.code) report_mismatch("wall_code", got.code, want.code);
          if (got.steps != want.steps) report_mismatch("step_count", got.steps, want.steps);
          if (got.span_start != want.span_start)
            report_mismatch("span_start", got.span_start, want.span_start);
          if (got.span_end != want.span_end)
            report_mismatch("span_end", got.span_end, want.span_end);
          if (got.status != want.status)
            report_mismatch("ray_status", got.status, want.status);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == CmdWrite) begin
          grid[s_axis_tdata[14:12] * MapDim + s_axis_tdata[17:15]] = s_axis_tdata[20:18];
        end else begin
          column_q.push_back(cast_column(s_axis_tdata[11:0]));
        end
      end
    end
  end
endmodule

[tb/grid_ray_march_column_tb.sv]
module grid_ray_march_column_tb;
  import grm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                s_axis_tvalid = 0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  fail_count;
  int                  pending;
  int                  burst_left = 0;
  int                  cycle_count = 0;
  logic [15:0]         stall_pattern = 16'hFFFF;
  int                  stall_phase = 0;
  int                  wall_density = 30;

  grid_ray_march_column u_top (.*);

  grm_march_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Receiver stalls follow a rotating pattern that is replaced now and then.
  always @(negedge clk_i) begin
    m_axis_tready <= stall_pattern[stall_phase];
    stall_phase <= (stall_phase + 1) % 16;
    if ($urandom_range(63) == 0)
      stall_pattern <= ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0101;
  end

  // Cycle limit guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("grid_ray_march_column test failed");
      $finish;
    end
  end

  // Sends one request; the sender idles between bursts of random length.
  task automatic send_request(logic kind, logic [InDataW-1:0] data);
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic write_cell(int row, int col, int code);
    send_request(CmdWrite, {3'b000, 3'(code), 3'(col), 3'(row), 12'h000});
  endtask

  task automatic cast(int col);
    send_request(CmdCast, {12'h000, 12'(col)});
  endtask

  // Holds off the sender until every result is back and the block has settled.
  task automatic drain;
    s_axis_tvalid <= 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // Writes all registers in consecutive cycles; the block must be idle.
  task automatic set_view(int px, int py, int st, int sp, int rows, int cols);
    int vals[6];
    logic [CfgIdxW-1:0] idx[6];
    vals = '{px, py, st, sp, rows, cols};
    idx = '{CfgPosX, CfgPosY, CfgStart, CfgSpan, CfgRows, CfgCols};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= 20'(vals[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 0;
    @(negedge clk_i);
  endtask

  function automatic int pick_pos();
    case ($urandom_range(5))
      0:       return -65536;
      1:       return 458751;
      default: return int'($urandom_range(524287)) - 65536;
    endcase
  endfunction

  function automatic int pick_screen();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 4096;
      2:       return 8191;
      3:       return $urandom_range(8191);
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: default view, border walls, high codes, start inside a wall.
    cast(0);
    cast(4095);
    write_cell(0, 0, 1);
    write_cell(7, 7, 7);
    for (int c = 0; c < 8; c++) write_cell(7, c, 2 + c % 3);
    cast(320);
    write_cell(4, 4, 5);
    cast(100);
    write_cell(4, 4, 0);
    write_cell(4, 6, 6);
    cast(0);
    drain();
    set_view(-65536, 458751, 65535, 65535, 0, 0);
    cast(0);
    cast(4095);
    drain();
    set_view(458751, -65536, 16384, 0, 8191, 4096);
    cast(4095);
    cast(1);
    drain();
    set_view(0, 0, 0, 65535, 1, 1);
    cast(2048);
    drain();

    // Random phases: new view and wall density, then map edits mixed with casts.
    for (int phase = 0; phase < 12; phase++) begin
      set_view(pick_pos(), pick_pos(), $urandom_range(65535), $urandom_range(65535),
               pick_screen(), pick_screen());
      wall_density = $urandom_range(60);
      for (int n = 0; n < 90; n++) begin
        if ($urandom_range(99) < 35)
          write_cell($urandom_range(7), $urandom_range(7),
                     ($urandom_range(99) < wall_density) ? $urandom_range(1, 7) : 0);
        else
          cast($urandom_range(4095));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("grid_ray_march_column test passed");
    end else begin
      $display("grid_ray_march_column test failed");
    end
    $finish;
  end
endmodule
